// ===== rtl/obl_pkg.sv =====
// ----------------------------------------------------------------------------
// obl_pkg
// shared codes and types for the ordered byte list
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package obl_pkg;

  // operation codes on the kind field
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SEARCH = 2'd2;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_EMPTY    = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd3;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_DELETE,
    CELL_ROTATE
  } cell_op_e;

  typedef struct packed {
    cell_op_e   op;
    logic [7:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/obl_cell.sv =====
// ----------------------------------------------------------------------------
// obl_cell
// one list slot: holds a byte, shifts to or from its neighbors
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module obl_cell
  import obl_pkg::*;
#(
  parameter int IDX_W = 6,
  parameter int INDEX = 0
) (
  input  wire logic             clk_i,
  input  wire cell_ctrl_t       ctrl_i,
  input  wire logic [IDX_W-1:0] sel_pos_i,
  input  wire logic [7:0]       prev_i,
  input  wire logic [7:0]       next_i,
  input  wire logic [7:0]       head_i,
  output logic      [7:0]       data_o
);

  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(INDEX);

  logic [7:0] data_q;
  logic [7:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (ctrl_i.op)
      CELL_INSERT: begin
        // cells past the slot take from the left, the slot takes the new byte
        if (MyIdx > sel_pos_i) begin
          data_d = prev_i;
        end else if (MyIdx == sel_pos_i) begin
          data_d = ctrl_i.value;
        end
      end
      CELL_DELETE: begin
        if (MyIdx >= sel_pos_i) begin
          data_d = next_i;
        end
      end
      CELL_ROTATE: begin
        // last used cell takes the head, the ones before it shift left
        if (MyIdx == sel_pos_i) begin
          data_d = head_i;
        end else if (MyIdx < sel_pos_i) begin
          data_d = next_i;
        end
      end
      CELL_HOLD: begin
        data_d = data_q;
      end
      default: begin
        data_d = data_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// ===== rtl/ordered_byte_list.sv =====
// ----------------------------------------------------------------------------
// ordered_byte_list
// bounded ordered list of bytes kept in a row of shifting cells
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_ready_o) carries one operation per
//   transaction: insert before a position, delete at a position, or search
//   for the first position holding a byte
//   output channel (out_valid_o / out_ready_i) carries exactly one result
//   transaction per operation: status, found position and element count
// throughput and search
//   insert, delete, the spare code and search of an empty list: result
//   registered on acceptance; all cells shift in parallel, so one such
//   transaction per cycle while the output register is empty or draining
//   search: the list rotates once through the chain of cells, the head
//   cell is compared with the probe each cycle, and the rotation restores order
// reset
//   element count clears to zero, no result pending; cell contents stay
//   undefined, only cells below the count are ever read
// stall
//   the result sits in the output register while out_ready_i is low; a new
//   transaction is taken only when that register is empty or draining
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_byte_list
  import obl_pkg::*;
#(
  parameter int CAPACITY = 64
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // operation channel
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [1:0] kind_i,
  input  wire logic [5:0] position_i,
  input  wire logic [7:0] value_i,
  // result channel
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic      [1:0] status_o,
  output logic      [5:0] found_position_o,
  output logic      [6:0] count_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width wide enough for both the position field and the count
  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  typedef enum logic {
    S_IDLE,
    S_SCAN
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [IDX_W-1:0] scan_q;
  logic [7:0]       probe_q;
  logic             found_q;
  logic [IDX_W-1:0] fpos_q;
  logic             out_valid_q;
  logic [1:0]       status_q;
  logic [5:0]       found_pos_q;

  cell_ctrl_t       cell_ctrl;
  logic [IDX_W-1:0] sel_pos;
  logic [7:0]       cell_data [CAPACITY];

  logic             in_acc;
  logic             list_full;
  logic             list_empty;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] last_ext;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] del_pos;
  logic [IDX_W-1:0] last_idx;
  logic             head_match;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign in_acc     = in_valid_i && in_ready_o;

  assign list_full  = (count_q == CNT_W'(CAPACITY));
  assign list_empty = (count_q == '0);

  // clamp positions: insert appends at or beyond count, delete takes the last
  assign pos_ext  = CMP_W'(position_i);
  assign cnt_ext  = CMP_W'(count_q);
  assign last_ext = cnt_ext - CMP_W'(1);
  assign ins_pos  = IDX_W'((pos_ext > cnt_ext) ? cnt_ext : pos_ext);
  assign del_pos  = IDX_W'((pos_ext >= last_ext) ? last_ext : pos_ext);
  assign last_idx = IDX_W'(last_ext);

  assign head_match = (cell_data[0] == probe_q);

  // control broadcast to every cell
  always_comb begin
    cell_ctrl.op    = CELL_HOLD;
    cell_ctrl.value = value_i;
    sel_pos         = '0;
    if (state_q == S_SCAN) begin
      cell_ctrl.op = CELL_ROTATE;
      sel_pos      = last_idx;
    end else if (in_acc) begin
      unique case (kind_i)
        KIND_INSERT: begin
          if (!list_full) begin
            cell_ctrl.op = CELL_INSERT;
            sel_pos      = ins_pos;
          end
        end
        KIND_DELETE: begin
          if (!list_empty) begin
            cell_ctrl.op = CELL_DELETE;
            sel_pos      = del_pos;
          end
        end
        default: begin
          cell_ctrl.op = CELL_HOLD;
        end
      endcase
    end
  end

  // the chain of cells
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [7:0] prev_data;
    logic [7:0] next_data;

    if (gi == 0) begin : g_first
      assign prev_data = value_i;
    end else begin : g_mid_prev
      assign prev_data = cell_data[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign next_data = cell_data[gi];
    end else begin : g_mid_next
      assign next_data = cell_data[gi+1];
    end

    obl_cell #(
      .IDX_W (IDX_W),
      .INDEX (gi)
    ) u_cell (
      .clk_i     (clk_i),
      .ctrl_i    (cell_ctrl),
      .sel_pos_i (sel_pos),
      .prev_i    (prev_data),
      .next_i    (next_data),
      .head_i    (cell_data[0]),
      .data_o    (cell_data[gi])
    );
  end

  // sequencer, element count and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      probe_q     <= '0;
      found_q     <= 1'b0;
      fpos_q      <= '0;
      out_valid_q <= 1'b0;
      status_q    <= STATUS_OK;
      found_pos_q <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            found_pos_q <= '0;
            unique case (kind_i)
              KIND_INSERT: begin
                out_valid_q <= 1'b1;
                if (list_full) begin
                  status_q <= STATUS_FULL;
                end else begin
                  status_q <= STATUS_OK;
                  count_q  <= count_q + CNT_W'(1);
                end
              end
              KIND_DELETE: begin
                out_valid_q <= 1'b1;
                if (list_empty) begin
                  status_q <= STATUS_EMPTY;
                end else begin
                  status_q <= STATUS_OK;
                  count_q  <= count_q - CNT_W'(1);
                end
              end
              KIND_SEARCH: begin
                if (list_empty) begin
                  out_valid_q <= 1'b1;
                  status_q    <= STATUS_NOTFOUND;
                end else begin
                  state_q <= S_SCAN;
                  scan_q  <= '0;
                  probe_q <= value_i;
                  found_q <= 1'b0;
                  fpos_q  <= '0;
                end
              end
              default: begin
                // spare code: nothing changes
                out_valid_q <= 1'b1;
                status_q    <= STATUS_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          // head holds original element scan_q during this cycle
          if (!found_q && head_match) begin
            found_q <= 1'b1;
            fpos_q  <= scan_q;
          end
          if (scan_q == last_idx) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            if (found_q) begin
              status_q    <= STATUS_OK;
              found_pos_q <= 6'(fpos_q);
            end else if (head_match) begin
              status_q    <= STATUS_OK;
              found_pos_q <= 6'(scan_q);
            end else begin
              status_q    <= STATUS_NOTFOUND;
              found_pos_q <= '0;
            end
          end else begin
            scan_q <= scan_q + IDX_W'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign found_position_o = found_pos_q;
  assign count_o          = 7'(count_q);

endmodule

`default_nettype wire
